// ===== sv/pcpc_pkg.sv =====
// Shared types, sizes and helpers for the periodic complementary pair check.
// No dependencies; used by every other file of the block except pcpc_out_buf.
`timescale 1ns / 1ps
`default_nettype none

package pcpc_pkg;

	localparam int SEQ_LEN    = 32;
	localparam int IN_W       = 32;
	localparam int NUM_SHIFTS = SEQ_LEN / 2;
	localparam int LOAD_W     = (SEQ_LEN < IN_W) ? SEQ_LEN : IN_W;
	localparam int CHUNK_W    = 8;
	localparam int NUM_CHUNKS = (SEQ_LEN + CHUNK_W - 1) / CHUNK_W;
	localparam int PAD_W      = NUM_CHUNKS * CHUNK_W;
	localparam int CNT_W      = $clog2(2 * CHUNK_W + 1);
	localparam int SUM_W      = $clog2(2 * SEQ_LEN + 1);

	typedef logic [SEQ_LEN-1:0] seq_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [SUM_W-1:0]   sum_t;

	// One beat moving from cell to cell: both sequences, their copies rotated
	// by the shift already tested, and the running verdict.
	typedef struct packed {
		logic valid;
		logic ok;
		seq_t a;
		seq_t b;
		seq_t ar;
		seq_t br;
	} chain_t;

	function automatic seq_t load_seq(input logic [IN_W-1:0] v);
		seq_t r;
		r = '0;
		for (int i = 0; i < LOAD_W; i++) begin
			r[i] = v[i];
		end
		return r;
	endfunction

	// rot[i] = x[(i + 1) mod SEQ_LEN]
	function automatic seq_t rot_one(input seq_t x);
		seq_t r;
		r = '0;
		for (int i = 0; i < SEQ_LEN - 1; i++) begin
			r[i] = x[i + 1];
		end
		r[SEQ_LEN-1] = x[0];
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/pcpc_cell.sv =====
// One cell of the shift chain: tests one cyclic shift in two register stages.
// Depends on pcpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcpc_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wire pcpc_pkg::chain_t prev,
	output pcpc_pkg::chain_t     next
);

	pcpc_pkg::seq_t rot_a;
	pcpc_pkg::seq_t rot_b;
	logic [pcpc_pkg::PAD_W-1:0] diff_a;
	logic [pcpc_pkg::PAD_W-1:0] diff_b;
	pcpc_pkg::cnt_t cnt [pcpc_pkg::NUM_CHUNKS];

	logic           valid_s1;
	logic           ok_s1;
	pcpc_pkg::seq_t a_s1;
	pcpc_pkg::seq_t b_s1;
	pcpc_pkg::seq_t ar_s1;
	pcpc_pkg::seq_t br_s1;
	pcpc_pkg::cnt_t cnt_s1 [pcpc_pkg::NUM_CHUNKS];

	pcpc_pkg::sum_t sum;

	logic           valid_s2;
	logic           ok_s2;
	pcpc_pkg::seq_t a_s2;
	pcpc_pkg::seq_t b_s2;
	pcpc_pkg::seq_t ar_s2;
	pcpc_pkg::seq_t br_s2;

	// stage 1: rotate one more place, mark differing positions, count per chunk
	always_comb begin
		rot_a  = pcpc_pkg::rot_one(prev.ar);
		rot_b  = pcpc_pkg::rot_one(prev.br);
		diff_a = '0;
		diff_b = '0;
		diff_a[pcpc_pkg::SEQ_LEN-1:0] = prev.a ^ rot_a;
		diff_b[pcpc_pkg::SEQ_LEN-1:0] = prev.b ^ rot_b;
		for (int c = 0; c < pcpc_pkg::NUM_CHUNKS; c++) begin
			cnt[c] = '0;
			for (int k = 0; k < pcpc_pkg::CHUNK_W; k++) begin
				cnt[c] = cnt[c] + pcpc_pkg::cnt_t'(diff_a[c*pcpc_pkg::CHUNK_W + k])
					+ pcpc_pkg::cnt_t'(diff_b[c*pcpc_pkg::CHUNK_W + k]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s1 <= prev.ok;
			a_s1  <= prev.a;
			b_s1  <= prev.b;
			ar_s1 <= rot_a;
			br_s1 <= rot_b;
			for (int c = 0; c < pcpc_pkg::NUM_CHUNKS; c++) begin
				cnt_s1[c] <= cnt[c];
			end
		end
	end

	// stage 2: autocorrelations cancel when the differing positions total SEQ_LEN
	always_comb begin
		sum = '0;
		for (int c = 0; c < pcpc_pkg::NUM_CHUNKS; c++) begin
			sum = sum + pcpc_pkg::sum_t'(cnt_s1[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s2 <= ok_s1 & (sum == pcpc_pkg::sum_t'(pcpc_pkg::SEQ_LEN));
			a_s2  <= a_s1;
			b_s2  <= b_s1;
			ar_s2 <= ar_s1;
			br_s2 <= br_s1;
		end
	end

	assign next.valid = valid_s2;
	assign next.ok    = ok_s2;
	assign next.a     = a_s2;
	assign next.b     = b_s2;
	assign next.ar    = ar_s2;
	assign next.br    = br_s2;

endmodule

`default_nettype wire

// ===== sv/pcpc_out_buf.sv =====
// Output register plus skid register for the result flag.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module pcpc_out_buf (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	input  wire  in_flag,
	output logic room,
	output logic out_valid,
	input  wire  out_ready,
	output logic out_flag
);

	logic out_valid_q;
	logic out_flag_q;
	logic skid_valid_q;
	logic skid_flag_q;
	logic take;
	logic drain;

	assign room  = !skid_valid_q;
	assign take  = room & in_valid;
	assign drain = !out_valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (drain) begin
			out_valid_q  <= skid_valid_q | take;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			out_flag_q <= skid_valid_q ? skid_flag_q : in_flag;
		end
		if (!drain && take) begin
			skid_flag_q <= in_flag;
		end
	end

	assign out_valid = out_valid_q;
	assign out_flag  = out_flag_q;

endmodule

`default_nettype wire

// ===== sv/periodic_complementary_pair_check.sv =====
// Periodic complementary pair check: takes one pair of packed +/-1 sequences per
// beat and returns one flag per beat, set when the two periodic autocorrelations
// cancel at every shift 1..SEQ_LEN/2. One pair is accepted every cycle while in_ready is
// high. A chain of SEQ_LEN/2 cells, each two register stages deep, tests one shift per
// cell; a result passes through every cell and then the output register. The output
// register and a one-deep skid register decouple the sides; in_ready falls only when
// both hold a result the sink has not taken.
// Depends on pcpc_pkg, pcpc_cell and pcpc_out_buf.
`timescale 1ns / 1ps
`default_nettype none

module periodic_complementary_pair_check (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire  [pcpc_pkg::IN_W-1:0]       first_signs,
	input  wire  [pcpc_pkg::IN_W-1:0]       second_signs,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic                            is_pair
);

	pcpc_pkg::chain_t link [pcpc_pkg::NUM_SHIFTS+1];
	logic             en;

	assign en = in_ready;

	assign link[0].valid = in_valid;
	assign link[0].ok    = 1'b1;
	assign link[0].a     = pcpc_pkg::load_seq(first_signs);
	assign link[0].b     = pcpc_pkg::load_seq(second_signs);
	assign link[0].ar    = pcpc_pkg::load_seq(first_signs);
	assign link[0].br    = pcpc_pkg::load_seq(second_signs);

	for (genvar g = 0; g < pcpc_pkg::NUM_SHIFTS; g++) begin : g_cell
		pcpc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.prev   (link[g]),
			.next   (link[g+1])
		);
	end

	pcpc_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (link[pcpc_pkg::NUM_SHIFTS].valid),
		.in_flag   (link[pcpc_pkg::NUM_SHIFTS].ok),
		.room      (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_flag  (is_pair)
	);

	// a full skid register implies a full output register
	a_skid_implies_out : assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("skid holds a result while output register is empty");

	// the chain freezes while stalled
	a_chain_holds : assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(link[pcpc_pkg::NUM_SHIFTS]))
		else $error("chain moved during stall");

	// a chain result arriving at a blocked output register fills the skid
	a_skid_fills : assert property (@(posedge clk) disable iff (!arst_n)
		(en && link[pcpc_pkg::NUM_SHIFTS].valid && out_valid && !out_ready)
		|=> !in_ready)
		else $error("result dropped at output");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for periodic_complementary_pair_check: directed corner pairs, scrambled
// Golay pairs, broken pairs and noise, all checked against an in-bench predictor.
// Depends on pcpc_pkg and the block's RTL; exercises both handshakes with random stalls.
`timescale 1ns / 1ps

module tb_top;

	localparam int W              = pcpc_pkg::IN_W;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int END_WAIT       = 2 * pcpc_pkg::SEQ_LEN;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         in_valid;
	logic         in_ready;
	logic [W-1:0] first_signs;
	logic [W-1:0] second_signs;
	logic         out_valid;
	logic         out_ready;
	logic         is_pair;

	logic pending_flags[$];
	logic want_flag;
	bit   idle_on;
	int   hold_request;
	int   pairs_sent;
	int   verdicts_seen;
	int   pairs_found;
	int   mismatches;
	int   quiet_cycles;
	int   stall_cycles;

	periodic_complementary_pair_check uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.first_signs  (first_signs),
		.second_signs (second_signs),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.is_pair      (is_pair)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// flag = both periodic autocorrelations cancel at every shift 1..n/2
	function automatic logic complementary_flag(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [63:0] x;
		logic [63:0] y;
		int n;
		int da;
		int db;
		int j;
		logic ok;
		n = pcpc_pkg::SEQ_LEN;
		if (n > 64) n = 64;
		if (n < 1) n = 1;
		x = '0;
		y = '0;
		for (int i = 0; i < n && i < W; i++) begin
			x[i] = a[i];
			y[i] = b[i];
		end
		ok = 1'b1;
		for (int s = 1; s <= n / 2; s++) begin
			da = 0;
			db = 0;
			for (int i = 0; i < n; i++) begin
				j = (i + s) % n;
				if (x[i] != x[j]) da++;
				if (y[i] != y[j]) db++;
			end
			if ((n - 2 * da) + (n - 2 * db) != 0) ok = 1'b0;
		end
		return ok;
	endfunction

	function automatic logic [W-1:0] rev_bits(input logic [W-1:0] x, input int len);
		logic [W-1:0] r;
		r = '0;
		for (int i = 0; i < len; i++) begin
			r[len-1-i] = x[i];
		end
		return r;
	endfunction

	function automatic logic [W-1:0] rot_left(input logic [W-1:0] x, input int r);
		return (x << r) | (x >> (W - r));
	endfunction

	// doubling construction a|b, a|-b; scrambling negates, reverses or swaps at each step
	function automatic void build_golay(input bit scramble, output logic [W-1:0] a,
			output logic [W-1:0] b);
		logic [W-1:0] na;
		logic [W-1:0] nb;
		logic [W-1:0] m;
		int len;
		a = '0;
		b = '0;
		len = 1;
		while (len < W) begin
			m = (W'(1) << len) - 1;
			if (scramble) begin
				if ($urandom_range(0, 1)) a = ~a & m;
				if ($urandom_range(0, 1)) b = ~b & m;
				if ($urandom_range(0, 1)) a = rev_bits(a, len);
				if ($urandom_range(0, 1)) b = rev_bits(b, len);
				if ($urandom_range(0, 1)) begin
					na = a;
					a = b;
					b = na;
				end
			end
			na = a | (b << len);
			nb = a | ((~b & m) << len);
			a = na;
			b = nb;
			len = len * 2;
		end
	endfunction

	// transforms that keep periodic complementarity
	function automatic void disguise_pair(inout logic [W-1:0] a, inout logic [W-1:0] b);
		logic [W-1:0] t;
		a = rot_left(a, $urandom_range(0, W - 1));
		b = rot_left(b, $urandom_range(0, W - 1));
		if ($urandom_range(0, 1)) a = ~a;
		if ($urandom_range(0, 1)) b = ~b;
		if ($urandom_range(0, 1)) a = rev_bits(a, W);
		if ($urandom_range(0, 1)) b = rev_bits(b, W);
		if ($urandom_range(0, 1)) begin
			a = a ^ {(W/2){2'b10}};
			b = b ^ {(W/2){2'b10}};
		end
		if ($urandom_range(0, 1)) begin
			t = a;
			a = b;
			b = t;
		end
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_pair(input logic [W-1:0] a, input logic [W-1:0] b);
		int gap;
		in_valid     <= 1'b1;
		first_signs  <= a;
		second_signs <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_flags.push_back(complementary_flag(a, b));
		pairs_sent++;
		if (idle_on && $urandom_range(0, 99) < 25) begin
			gap = pick_gap();
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic test_corner_pairs();
		logic [W-1:0] ga;
		logic [W-1:0] gb;
		idle_on = 1'b1;
		send_pair('0, '0);
		send_pair('1, '1);
		send_pair('0, '1);
		send_pair('1, '0);
		send_pair({(W/2){2'b10}}, {(W/2){2'b01}});
		send_pair({(W/2){2'b10}}, {(W/2){2'b10}});
		send_pair({{(W/2){1'b1}}, {(W/2){1'b0}}}, {{(W/2){1'b0}}, {(W/2){1'b1}}});
		send_pair(W'(1), '0);
		send_pair({1'b1, {(W-1){1'b0}}}, '1);
		build_golay(1'b0, ga, gb);
		send_pair(ga, gb);
		send_pair(~ga, gb);
		send_pair(rot_left(ga, 1), rot_left(gb, W - 1));
		send_pair(rev_bits(ga, W), gb);
		send_pair(ga ^ {(W/2){2'b10}}, gb ^ {(W/2){2'b10}});
		send_pair(gb, ga);
		send_pair(ga ^ W'(1), gb);
		send_pair(ga, gb ^ {1'b1, {(W-1){1'b0}}});
		send_pair(ga, ga);
	endtask

	task automatic test_golay_pairs(input int count);
		logic [W-1:0] a;
		logic [W-1:0] b;
		idle_on = 1'b1;
		repeat (count) begin
			build_golay(1'b1, a, b);
			disguise_pair(a, b);
			send_pair(a, b);
		end
	endtask

	task automatic test_broken_and_noise(input int broken, input int noise);
		logic [W-1:0] a;
		logic [W-1:0] b;
		idle_on = 1'b1;
		repeat (broken) begin
			build_golay(1'b1, a, b);
			disguise_pair(a, b);
			a[$urandom_range(0, W - 1)] ^= 1'b1;
			if ($urandom_range(0, 1)) b[$urandom_range(0, W - 1)] ^= 1'b1;
			send_pair(a, b);
		end
		repeat (noise) send_pair($urandom, $urandom);
	endtask

	task automatic test_backpressure(input int count);
		logic [W-1:0] a;
		logic [W-1:0] b;
		idle_on = 1'b0;
		hold_request = 150;
		repeat (count) begin
			build_golay(1'b1, a, b);
			disguise_pair(a, b);
			if ($urandom_range(0, 2) == 0) b = $urandom;
			send_pair(a, b);
		end
	endtask

	task automatic test_full_rate(input int count);
		logic [W-1:0] a;
		logic [W-1:0] b;
		idle_on = 1'b0;
		repeat (count) begin
			build_golay(1'b1, a, b);
			disguise_pair(a, b);
			if ($urandom_range(0, 1)) a = $urandom;
			send_pair(a, b);
		end
		idle_on = 1'b1;
	endtask

	initial begin
		int gap_left;
		gap_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				gap_left = hold_request;
				hold_request = 0;
			end
			if (gap_left > 0) begin
				out_ready <= 1'b0;
				gap_left--;
			end else if (idle_on && $urandom_range(0, 99) < 25) begin
				gap_left = pick_gap() - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_flags.size() == 0) begin
				$error("is_pair: beat with nothing pending, got %0b", is_pair);
				mismatches++;
			end else begin
				want_flag = pending_flags.pop_front();
				if (is_pair !== want_flag) begin
					$error("is_pair: expected %0b, got %0b", want_flag, is_pair);
					mismatches++;
				end
				verdicts_seen++;
				if (is_pair === 1'b1) pairs_found++;
			end
		end
	end

	always @(posedge clk) begin
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", quiet_cycles);
			$display("tb_top NOT OK");
			$finish;
		end else begin
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (arst_n && in_valid && !in_ready) stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		idle_on       = 1'b1;
		hold_request  = 0;
		pairs_sent    = 0;
		verdicts_seen = 0;
		pairs_found   = 0;
		mismatches    = 0;
		quiet_cycles  = 0;
		stall_cycles  = 0;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		first_signs  <= '0;
		second_signs <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_pairs();
		test_golay_pairs(300);
		test_backpressure(70);
		test_broken_and_noise(60, 120);
		test_full_rate(60);

		in_valid <= 1'b0;
		while (pending_flags.size() != 0) @(posedge clk);
		repeat (END_WAIT) @(posedge clk);

		$display("%0d pairs sent, %0d verdicts checked, %0d complementary, %0d mismatches",
			pairs_sent, verdicts_seen, pairs_found, mismatches);
		$display("input held off for %0d cycles by output stalls", stall_cycles);
		if (mismatches == 0 && pending_flags.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/pcpc_pkg.sv
sv/pcpc_cell.sv
sv/pcpc_out_buf.sv
sv/periodic_complementary_pair_check.sv
dv/tb_top.sv
